FILE: src/ecc_pkg.sv
package ecc_pkg;

    // calendar constants
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_PER_HOUR = 3600;
    localparam int SECS_PER_MIN  = 60;
    localparam int DAYS_PER_ERA  = 146097;
    localparam int DAYS_PER_YEAR = 365;
    localparam int YEARS_PER_ERA = 400;
    localparam int EPOCH_SHIFT   = 719468;

    // register stages inside each datapath, the output register comes on top
    localparam int DP_STAGES = 6;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;

    // action codes
    localparam logic ACT_TO_DATE = 1'b0;
    localparam logic ACT_TO_SECS = 1'b1;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date_in;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_date_out;

    // days from march 1 to the first of the month with march-based index mp
    function automatic logic [8:0] days_before(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/ecc_cdiv.sv
// unsigned division by a constant: one multiply by a rounded-up reciprocal
module ecc_cdiv #(
    parameter int N  = 16,
    parameter int D  = 10,
    parameter int QW = 8
) (
    input  logic [N-1:0]  i_x,
    output logic [QW-1:0] o_q
);

    // shift wide enough that the rounding error never reaches the next integer
    localparam int S  = N + $clog2(D);
    localparam int PW = S + QW;
    localparam logic [PW-1:0] M = PW'(((64'd1 << S) + 64'(D) - 64'd1) / 64'(D));

    logic [PW-1:0] prod;

    assign prod = PW'(i_x) * M;
    assign o_q  = prod[PW-1:S];

endmodule

FILE: src/ecc_sec2date.sv
// epoch seconds to calendar date and time of day
module ecc_sec2date (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [30:0]       i_secs,
    output ecc_pkg::t_date_out o_date
);

    // stage 1: day count
    logic [14:0] days_q;
    logic [14:0] r1_days;
    logic [30:0] r1_secs;

    ecc_cdiv #(.N(24), .D(ecc_pkg::SECS_PER_DAY / 128), .QW(15)) u_div_day (
        .i_x (i_secs[30:7]),
        .o_q (days_q)
    );

    // stage 2: time of day, era and day of era
    localparam int ERA4_DAYS = 4 * ecc_pkg::DAYS_PER_ERA;
    localparam int ERA5_DAYS = 5 * ecc_pkg::DAYS_PER_ERA;

    logic [31:0] n_tod_full;
    logic [19:0] n_dd;
    logic        n_era5;
    logic [19:0] n_doe_full;
    logic [16:0] r2_tod;
    logic [17:0] r2_doe;
    logic        r2_era5;

    always_comb begin
        n_tod_full = 32'(r1_secs) - 32'(r1_days) * 32'(ecc_pkg::SECS_PER_DAY);
        n_dd       = 20'(r1_days) + 20'(ecc_pkg::EPOCH_SHIFT);
        // a 31-bit count of seconds only reaches era 4 or era 5
        n_era5     = (n_dd >= 20'(ERA5_DAYS));
        n_doe_full = n_dd - (n_era5 ? 20'(ERA5_DAYS) : 20'(ERA4_DAYS));
    end

    // stage 3: leap corrected day count and hour
    logic [6:0]  q1460;
    logic [4:0]  hour_q;
    logic [2:0]  n_c36524;
    logic        n_last_day;
    logic [17:0] n_ncount;
    logic [17:0] r3_n;
    logic [17:0] r3_doe;
    logic        r3_era5;
    logic [16:0] r3_tod;
    logic [4:0]  r3_hour;

    ecc_cdiv #(.N(18), .D(1460), .QW(7)) u_div_1460 (
        .i_x (r2_doe),
        .o_q (q1460)
    );

    ecc_cdiv #(.N(17), .D(ecc_pkg::SECS_PER_HOUR), .QW(5)) u_div_hour (
        .i_x (r2_tod),
        .o_q (hour_q)
    );

    always_comb begin
        n_c36524   = 3'(r2_doe >= 18'd36524) + 3'(r2_doe >= 18'd73048)
                   + 3'(r2_doe >= 18'd109572) + 3'(r2_doe >= 18'd146096);
        n_last_day = (r2_doe == 18'd146096);
        n_ncount   = r2_doe - 18'(q1460) + 18'(n_c36524) - 18'(n_last_day);
    end

    // stage 4: year of era and seconds within the hour
    logic [8:0]  yoe_q;
    logic [11:0] n_remh;
    logic [8:0]  r4_yoe;
    logic [17:0] r4_doe;
    logic        r4_era5;
    logic [4:0]  r4_hour;
    logic [11:0] r4_remh;

    ecc_cdiv #(.N(18), .D(ecc_pkg::DAYS_PER_YEAR), .QW(9)) u_div_year (
        .i_x (r3_n),
        .o_q (yoe_q)
    );

    assign n_remh = 12'(r3_tod - 17'(r3_hour) * 17'(ecc_pkg::SECS_PER_HOUR));

    // stage 5: day of year, march-based year, minute
    logic [1:0]  n_c100;
    logic [17:0] n_ybase;
    logic [8:0]  n_doy;
    logic [11:0] n_y;
    logic [5:0]  min_q;
    logic [8:0]  r5_doy;
    logic [11:0] r5_y;
    logic [4:0]  r5_hour;
    logic [5:0]  r5_min;
    logic [11:0] r5_remh;

    ecc_cdiv #(.N(12), .D(ecc_pkg::SECS_PER_MIN), .QW(6)) u_div_min (
        .i_x (r4_remh),
        .o_q (min_q)
    );

    always_comb begin
        n_c100  = 2'(r4_yoe >= 9'd100) + 2'(r4_yoe >= 9'd200) + 2'(r4_yoe >= 9'd300);
        n_ybase = 18'(r4_yoe) * 18'(ecc_pkg::DAYS_PER_YEAR) + 18'(r4_yoe[8:2]) - 18'(n_c100);
        n_doy   = 9'(r4_doe - n_ybase);
        n_y     = 12'(r4_yoe) + (r4_era5 ? 12'(5 * ecc_pkg::YEARS_PER_ERA)
                                         : 12'(4 * ecc_pkg::YEARS_PER_ERA));
    end

    // stage 6: march-based month and second
    logic [10:0] n_mp_num;
    logic [3:0]  mp_q;
    logic [8:0]  r6_doy;
    logic [3:0]  r6_mp;
    logic [11:0] r6_y;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_min;
    logic [5:0]  r6_sec;

    assign n_mp_num = 11'(r5_doy) * 11'd5 + 11'd2;

    ecc_cdiv #(.N(11), .D(153), .QW(4)) u_div_mp (
        .i_x (n_mp_num),
        .o_q (mp_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_days <= days_q;
            r1_secs <= i_secs;

            r2_tod  <= n_tod_full[16:0];
            r2_doe  <= n_doe_full[17:0];
            r2_era5 <= n_era5;

            r3_n    <= n_ncount;
            r3_doe  <= r2_doe;
            r3_era5 <= r2_era5;
            r3_tod  <= r2_tod;
            r3_hour <= hour_q;

            r4_yoe  <= yoe_q;
            r4_doe  <= r3_doe;
            r4_era5 <= r3_era5;
            r4_hour <= r3_hour;
            r4_remh <= n_remh;

            r5_doy  <= n_doy;
            r5_y    <= n_y;
            r5_hour <= r4_hour;
            r5_min  <= min_q;
            r5_remh <= r4_remh;

            r6_doy  <= r5_doy;
            r6_mp   <= mp_q;
            r6_y    <= r5_y;
            r6_hour <= r5_hour;
            r6_min  <= r5_min;
            r6_sec  <= 6'(r5_remh - 12'(r5_min) * 12'(ecc_pkg::SECS_PER_MIN));
        end
    end

    // final: day of month, january and february move into the next year
    logic [8:0]  day_full;
    logic [3:0]  month;
    logic [11:0] year_full;

    always_comb begin
        day_full  = r6_doy - ecc_pkg::days_before(r6_mp) + 9'd1;
        month     = (r6_mp < 4'd10) ? r6_mp + 4'd3 : r6_mp - 4'd9;
        year_full = r6_y + 12'(month <= 4'd2);
    end

    assign o_date.year   = year_full[10:0];
    assign o_date.month  = month;
    assign o_date.day    = day_full[4:0];
    assign o_date.hour   = r6_hour;
    assign o_date.minute = r6_min;
    assign o_date.second = r6_sec;

endmodule

FILE: src/ecc_date2sec.sv
// calendar date and time of day to epoch seconds modulo 2^32
module ecc_date2sec (
    input  logic             i_clk,
    input  logic             i_en,
    input  ecc_pkg::t_date_in i_date,
    output logic [31:0]      o_total
);

    // stage 1: march-based year, era estimate, day of year, time of day
    logic        n_dec;
    logic        n_neg;
    logic [13:0] n_yp;
    logic [5:0]  q400;
    logic [3:0]  n_mp;
    logic signed [9:0] n_doy;
    logic [16:0] n_hms;

    logic [13:0] r1_yp;
    logic [5:0]  r1_q400;
    logic        r1_neg;
    logic signed [9:0] r1_doy;
    logic [16:0] r1_hms;

    always_comb begin
        n_dec = (i_date.month <= 4'd2);
        // year zero with january or february falls into the era before
        n_neg = n_dec && (i_date.year == 14'd0);
        n_yp  = i_date.year - 14'(n_dec);
        n_mp  = n_dec ? i_date.month + 4'd9 : i_date.month - 4'd3;
        n_doy = $signed({1'b0, ecc_pkg::days_before(n_mp)})
              + $signed({5'b0, i_date.day}) - 10'sd1;
        n_hms = 17'(i_date.hour) * 17'(ecc_pkg::SECS_PER_HOUR)
              + 17'(i_date.minute) * 17'(ecc_pkg::SECS_PER_MIN)
              + 17'(i_date.second);
    end

    ecc_cdiv #(.N(14), .D(ecc_pkg::YEARS_PER_ERA), .QW(6)) u_div_era (
        .i_x (n_yp),
        .o_q (q400)
    );

    // stage 2: year of era
    logic [8:0]        r2_yoe;
    logic signed [6:0] r2_era;
    logic signed [9:0] r2_doy;
    logic [16:0]       r2_hms;

    // stage 3: day of era and era offset
    logic [1:0]         n_c100;
    logic signed [18:0] n_doe;
    logic signed [18:0] r3_doe;
    logic signed [23:0] r3_era_days;
    logic [16:0]        r3_hms;

    always_comb begin
        n_c100 = 2'(r2_yoe >= 9'd100) + 2'(r2_yoe >= 9'd200) + 2'(r2_yoe >= 9'd300);
        n_doe  = $signed(19'(r2_yoe) * 19'(ecc_pkg::DAYS_PER_YEAR)
                         + 19'(r2_yoe[8:2]) - 19'(n_c100))
               + {{9{r2_doy[9]}}, r2_doy};
    end

    // stage 4..6: days since epoch, scale to seconds, add time of day
    logic signed [23:0] r4_days;
    logic [16:0]        r4_hms;
    logic [31:0]        r5_prod;
    logic [16:0]        r5_hms;
    logic [31:0]        r6_total;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_yp   <= n_yp;
            r1_q400 <= q400;
            r1_neg  <= n_neg;
            r1_doy  <= n_doy;
            r1_hms  <= n_hms;

            r2_yoe  <= r1_neg ? 9'(ecc_pkg::YEARS_PER_ERA - 1)
                              : 9'(r1_yp - 14'(r1_q400) * 14'(ecc_pkg::YEARS_PER_ERA));
            r2_era  <= r1_neg ? -7'sd1 : $signed({1'b0, r1_q400});
            r2_doy  <= r1_doy;
            r2_hms  <= r1_hms;

            r3_doe      <= n_doe;
            r3_era_days <= $signed({{17{r2_era[6]}}, r2_era})
                         * $signed(24'(ecc_pkg::DAYS_PER_ERA));
            r3_hms      <= r2_hms;

            r4_days <= r3_era_days + {{5{r3_doe[18]}}, r3_doe}
                     - $signed(24'(ecc_pkg::EPOCH_SHIFT));
            r4_hms  <= r3_hms;

            r5_prod <= {{8{r4_days[23]}}, r4_days} * 32'(ecc_pkg::SECS_PER_DAY);
            r5_hms  <= r4_hms;

            r6_total <= r5_prod + 32'(r5_hms);
        end
    end

    assign o_total = r6_total;

endmodule

FILE: src/epoch_calendar_converter.sv
// path: an accepted request passes the datapath stages and then the output register to the master side
// throughput: one request per cycle; the whole pipeline moves together and
//   halts only while the output register holds a result that is not taken
// reset: i_rst_n synchronous, active low, clears the stage valid bits and the
//   output valid; datapath registers are not reset
module epoch_calendar_converter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [30:0] epoch_seconds, [44:31] in_year, [48:45] in_month, [53:49] in_day,
    // [58:54] in_hour, [64:59] in_minute, [70:65] in_second, [71] zero
    input  logic [ecc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic [0:0]                     s_axis_tuser,

    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] total_seconds, [42:32] out_year, [46:43] out_month, [51:47] out_day,
    // [56:52] out_hour, [62:57] out_minute, [68:63] out_second, [71:69] zero
    output logic [ecc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int NST = ecc_pkg::DP_STAGES;

    // the whole pipeline advances unless a finished result is stalled
    logic w_adv;

    // stage valid and action bits travel alongside the two datapaths
    logic [NST-1:0] r_vld;
    logic [NST-1:0] r_act;

    logic                r_out_vld;
    logic                r_out_act;
    logic [31:0]         r_out_total;
    ecc_pkg::t_date_out  r_out_date;

    // request unpacking
    logic [30:0]        w_secs;
    ecc_pkg::t_date_in  w_date_in;

    assign w_secs           = s_axis_tdata[30:0];
    assign w_date_in.year   = s_axis_tdata[44:31];
    assign w_date_in.month  = s_axis_tdata[48:45];
    assign w_date_in.day    = s_axis_tdata[53:49];
    assign w_date_in.hour   = s_axis_tdata[58:54];
    assign w_date_in.minute = s_axis_tdata[64:59];
    assign w_date_in.second = s_axis_tdata[70:65];

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // both conversions run on every request; the action picks the result
    ecc_pkg::t_date_out w_date_out;
    logic [31:0]        w_total;

    ecc_sec2date u_sec2date (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_secs (w_secs),
        .o_date (w_date_out)
    );

    ecc_date2sec u_date2sec (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_date  (w_date_in),
        .o_total (w_total)
    );

    // valid bits, reset only on control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld     <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[NST-1];
        end
    end

    // action tags and output register, unused result fields forced to zero
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_act     <= {r_act[NST-2:0], s_axis_tuser[0]};
            r_out_act <= r_act[NST-1];
            if (r_act[NST-1] == ecc_pkg::ACT_TO_SECS) begin
                r_out_total <= w_total;
                r_out_date  <= '0;
            end else begin
                r_out_total <= '0;
                r_out_date  <= w_date_out;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_date.second, r_out_date.minute, r_out_date.hour,
                            r_out_date.day, r_out_date.month, r_out_date.year, r_out_total};

`ifndef SYNTHESIS
    // a stalled result must block new requests
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    // an accepted request enters the first stage
    a_entry_tracks_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_adv) |-> r_vld[0] == $past(s_axis_tvalid))
        else $error("first stage valid does not follow the request handshake");

    // date results carry no seconds count
    a_date_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_act == ecc_pkg::ACT_TO_DATE |-> r_out_total == '0)
        else $error("seconds field not zero on date result");

    // seconds results carry no date
    a_secs_zero_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_act == ecc_pkg::ACT_TO_SECS |-> r_out_date == '0)
        else $error("date fields not zero on seconds result");

    // a converted date always has a real month
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out_act == ecc_pkg::ACT_TO_DATE
            |-> r_out_date.month >= 4'd1 && r_out_date.month <= 4'd12)
        else $error("month out of range on date result");
`endif

endmodule
